// ===== rtl/core/frlr_pkg.sv =====
package frlr_pkg;

   // default frame geometry
   localparam int DEF_MAX_RES_X = 64;
   localparam int DEF_MAX_RES_Y = 64;

   // field and datapath widths
   localparam int LW      = 16;   // coordinate field width
   localparam int CW      = 18;   // signed width for coordinate sums and checks
   localparam int DW      = 20;   // signed width of the line decision term
   localparam int COLOR_W = 32;
   localparam int RES_W   = 7;
   localparam int CMPW    = 16;   // width for clamping the resolution registers

   localparam logic [RES_W-1:0] RES_RESET = RES_W'(64);

   typedef enum logic [2:0] {
      CMD_PLOT    = 3'd0,
      CMD_FILL    = 3'd1,
      CMD_OUTLINE = 3'd2,
      CMD_LINE    = 3'd3,
      CMD_CLEAR   = 3'd4,
      CMD_SWAP    = 3'd5,
      CMD_READ    = 3'd6,
      CMD_NONE    = 3'd7
   } cmd_type;

   typedef enum logic {
      CSR_RES_X = 1'b0,
      CSR_RES_Y = 1'b1
   } csr_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_FILL,
      ST_EDGE,
      ST_LSET1,
      ST_LSET2,
      ST_LINE,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]           cmd;
      logic signed [LW-1:0] ax;
      logic signed [LW-1:0] ay;
      logic signed [LW-1:0] bx;
      logic signed [LW-1:0] by;
      logic [COLOR_W-1:0]   color;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_value;
      logic               rejected;
   } rsp_type;

   // status from the sequencer to the result stage
   typedef struct packed {
      logic done;
      logic rejected;
      logic rd;
   } stat_type;

endpackage

// ===== rtl/core/frlr_ram.sv =====
module frlr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/frlr_seq.sv =====
module frlr_seq import frlr_pkg::*; #(
   parameter int MAX_RES_X = DEF_MAX_RES_X,
   parameter int MAX_RES_Y = DEF_MAX_RES_Y,
   localparam int XW = $clog2(MAX_RES_X),
   localparam int YW = $clog2(MAX_RES_Y),
   localparam int XE = $clog2(MAX_RES_X + 1),
   localparam int YE = $clog2(MAX_RES_Y + 1),
   localparam int AW = $clog2(2 * MAX_RES_X * MAX_RES_Y)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   input  logic [XE-1:0]      act_w,
   input  logic [YE-1:0]      act_h,
   output logic               mem_we,
   output logic               mem_re,
   output logic [AW-1:0]      mem_addr,
   output logic [COLOR_W-1:0] mem_wdata,
   output stat_type           stat
);

   localparam logic [AW-1:0] PLANE  = AW'(MAX_RES_X * MAX_RES_Y);
   localparam logic [AW-1:0] ROW    = AW'(MAX_RES_X);
   localparam logic [AW-1:0] SW_ALL = AW'(2 * MAX_RES_X * MAX_RES_Y - 1);

   state_type state_ff, state_in;
   logic draw_sel_ff, draw_sel_in;
   logic rej_ff, rej_in;
   logic rd_ff, rd_in;
   logic any_ff, any_in;
   logic outline_ff, outline_in;
   logic [1:0] side_ff, side_in;
   logic signed [LW-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [CW-1:0] ey1_ff, ey1_in, ex3_ff, ex3_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [XW-1:0] sc_x_ff, sc_x_in, sc_x0_ff, sc_x0_in;
   logic [XE-1:0] sc_xe_ff, sc_xe_in;
   logic [YW-1:0] sc_y_ff, sc_y_in;
   logic [YE-1:0] sc_ye_ff, sc_ye_in;
   logic major_ff, major_in;
   logic signed [LW-1:0] ln_a_ff, ln_a_in, ln_b_ff, ln_b_in, ln_a1_ff, ln_a1_in;
   logic signed [DW-1:0] ln_d_ff, ln_d_in, ln_k1_ff, ln_k1_in, ln_k2_ff, ln_k2_in;
   logic ln_dec_ff, ln_dec_in;
   logic [AW-1:0] sw_ff, sw_in, sw_end_ff, sw_end_in;
   logic pix_en_ff, pix_en_in, pix_rd_ff, pix_rd_in, pix_plane_ff, pix_plane_in;
   logic [XW-1:0] pix_x_ff, pix_x_in;
   logic [YW-1:0] pix_y_ff, pix_y_in;

   logic signed [CW-1:0] aw_s, ah_s;
   logic signed [CW-1:0] rx, ry, rbx, rby;
   logic signed [CW-1:0] e_x, e_y, e_len, e_xe, e_ye;
   logic e_vert, e_ok, fill_ok, accept;
   logic signed [CW-1:0] l_dx, l_dy, l_adx, l_ady;
   logic signed [LW-1:0] a0, b0, a1, b1;
   logic signed [CW-1:0] l_da, l_dbr, l_db;
   logic signed [LW-1:0] px, py;
   logic l_ok, last_col, last_row, sweeping;
   logic [AW-1:0] pix_addr;

   function automatic logic on_scr(input logic signed [CW-1:0] x, y, w, h);
      return (x >= 0) && (y >= 0) && (x < w) && (y < h);
   endfunction

   assign aw_s   = $signed(CW'(act_w));
   assign ah_s   = $signed(CW'(act_h));
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // command fields widened for bounds checks
   assign rx  = CW'($signed(req_data.ax));
   assign ry  = CW'($signed(req_data.ay));
   assign rbx = CW'($signed(req_data.bx));
   assign rby = CW'($signed(req_data.by));
   assign fill_ok = on_scr(rx, ry, aw_s, ah_s) && (rbx > 0) && (rby > 0) &&
                    (rx + rbx <= aw_s) && (ry + rby <= ah_s);

   // current outline edge and its bounds check
   always_comb begin
      e_x    = CW'(ax_ff);
      e_y    = CW'(ay_ff);
      e_len  = CW'(bx_ff);
      e_vert = 1'b0;
      unique case (side_ff)
         2'd0: begin
            e_len = CW'(bx_ff);
         end
         2'd1: begin
            e_y = ey1_ff;
         end
         2'd2: begin
            e_len  = CW'(by_ff);
            e_vert = 1'b1;
         end
         default: begin
            e_x    = ex3_ff;
            e_len  = CW'(by_ff);
            e_vert = 1'b1;
         end
      endcase
      e_xe = e_vert ? e_x + CW'(1) : e_x + e_len;
      e_ye = e_vert ? e_y + e_len : e_y + CW'(1);
      e_ok = on_scr(e_x, e_y, aw_s, ah_s) && (e_len > 0) &&
             (e_vert ? (e_ye <= ah_s) : (e_xe <= aw_s));
   end

   // line setup: major axis, ordered end points, error terms
   always_comb begin
      l_dx  = CW'(bx_ff) - CW'(ax_ff);
      l_dy  = CW'(by_ff) - CW'(ay_ff);
      l_adx = (l_dx < 0) ? -l_dx : l_dx;
      l_ady = (l_dy < 0) ? -l_dy : l_dy;
      if (major_ff) begin
         if (ax_ff > bx_ff) begin
            a0 = bx_ff; b0 = by_ff; a1 = ax_ff; b1 = ay_ff;
         end else begin
            a0 = ax_ff; b0 = ay_ff; a1 = bx_ff; b1 = by_ff;
         end
      end else begin
         if (ay_ff > by_ff) begin
            a0 = by_ff; b0 = bx_ff; a1 = ay_ff; b1 = ax_ff;
         end else begin
            a0 = ay_ff; b0 = ax_ff; a1 = by_ff; b1 = bx_ff;
         end
      end
      l_da  = CW'(a1) - CW'(a0);
      l_dbr = CW'(b1) - CW'(b0);
      l_db  = (l_dbr < 0) ? -l_dbr : l_dbr;
   end

   // line pixel for this step
   assign px   = major_ff ? ln_a_ff : ln_b_ff;
   assign py   = major_ff ? ln_b_ff : ln_a_ff;
   assign l_ok = on_scr(CW'(px), CW'(py), aw_s, ah_s);

   assign last_col = (XE'(sc_x_ff) + XE'(1)) == sc_xe_ff;
   assign last_row = (YE'(sc_y_ff) + YE'(1)) == sc_ye_ff;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      draw_sel_in  = draw_sel_ff;
      rej_in       = rej_ff;
      rd_in        = rd_ff;
      any_in       = any_ff;
      outline_in   = outline_ff;
      side_in      = side_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      ey1_in       = ey1_ff;
      ex3_in       = ex3_ff;
      color_in     = color_ff;
      sc_x_in      = sc_x_ff;
      sc_x0_in     = sc_x0_ff;
      sc_xe_in     = sc_xe_ff;
      sc_y_in      = sc_y_ff;
      sc_ye_in     = sc_ye_ff;
      major_in     = major_ff;
      ln_a_in      = ln_a_ff;
      ln_b_in      = ln_b_ff;
      ln_a1_in     = ln_a1_ff;
      ln_d_in      = ln_d_ff;
      ln_k1_in     = ln_k1_ff;
      ln_k2_in     = ln_k2_ff;
      ln_dec_in    = ln_dec_ff;
      sw_in        = sw_ff;
      sw_end_in    = sw_end_ff;
      pix_en_in    = 1'b0;
      pix_rd_in    = 1'b0;
      pix_plane_in = draw_sel_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;

      unique case (state_ff)
         ST_INIT: begin
            sw_in = sw_ff + AW'(1);
            if (sw_ff == sw_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rej_in     = 1'b0;
               rd_in      = 1'b0;
               outline_in = 1'b0;
               ax_in      = req_data.ax;
               ay_in      = req_data.ay;
               bx_in      = req_data.bx;
               by_in      = req_data.by;
               ey1_in     = ry + rby - CW'(1);
               ex3_in     = rx + rbx - CW'(1);
               color_in   = req_data.color;
               sc_x_in    = rx[XW-1:0];
               sc_x0_in   = rx[XW-1:0];
               sc_y_in    = ry[YW-1:0];
               state_in   = ST_DONE;
               unique case (cmd_type'(req_data.cmd))
                  CMD_PLOT: begin
                     sc_xe_in = XE'(rx + CW'(1));
                     sc_ye_in = YE'(ry + CW'(1));
                     if (on_scr(rx, ry, aw_s, ah_s)) begin
                        state_in = ST_FILL;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end
                  CMD_FILL: begin
                     sc_xe_in = XE'(rx + rbx);
                     sc_ye_in = YE'(ry + rby);
                     if (fill_ok) begin
                        state_in = ST_FILL;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end
                  CMD_OUTLINE: begin
                     if (rbx < 0 || rby < 0) begin
                        rej_in = 1'b1;
                     end else begin
                        outline_in = 1'b1;
                        side_in    = 2'd0;
                        any_in     = 1'b0;
                        state_in   = ST_EDGE;
                     end
                  end
                  CMD_LINE: begin
                     state_in = ST_LSET1;
                  end
                  CMD_CLEAR: begin
                     sw_in     = draw_sel_ff ? PLANE : '0;
                     sw_end_in = (draw_sel_ff ? PLANE : '0) + PLANE - AW'(1);
                     state_in  = ST_CLEAR;
                  end
                  CMD_SWAP: begin
                     draw_sel_in = ~draw_sel_ff;
                  end
                  CMD_READ: begin
                     if (on_scr(rx, ry, aw_s, ah_s)) begin
                        pix_en_in    = 1'b1;
                        pix_rd_in    = 1'b1;
                        pix_plane_in = ~draw_sel_ff;
                        pix_x_in     = rx[XW-1:0];
                        pix_y_in     = ry[YW-1:0];
                        rd_in        = 1'b1;
                        state_in     = ST_READ;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            pix_en_in = 1'b1;
            pix_x_in  = sc_x_ff;
            pix_y_in  = sc_y_ff;
            if (!last_col) begin
               sc_x_in = sc_x_ff + XW'(1);
            end else begin
               sc_x_in = sc_x0_ff;
               if (!last_row) begin
                  sc_y_in = sc_y_ff + YW'(1);
               end else if (outline_ff && side_ff != 2'd3) begin
                  side_in  = side_ff + 2'd1;
                  state_in = ST_EDGE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_EDGE: begin
            if (e_ok) begin
               any_in   = 1'b1;
               sc_x_in  = e_x[XW-1:0];
               sc_x0_in = e_x[XW-1:0];
               sc_y_in  = e_y[YW-1:0];
               sc_xe_in = e_xe[XE-1:0];
               sc_ye_in = e_ye[YE-1:0];
               state_in = ST_FILL;
            end else if (side_ff == 2'd3) begin
               rej_in   = !any_ff;
               state_in = ST_DONE;
            end else begin
               side_in = side_ff + 2'd1;
            end
         end
         ST_LSET1: begin
            major_in = l_ady < l_adx;
            state_in = ST_LSET2;
         end
         ST_LSET2: begin
            ln_a_in   = a0;
            ln_b_in   = b0;
            ln_a1_in  = a1;
            ln_dec_in = l_dbr < 0;
            ln_d_in   = (DW'(l_db) <<< 1) - DW'(l_da);
            ln_k1_in  = (DW'(l_db) - DW'(l_da)) <<< 1;
            ln_k2_in  = DW'(l_db) <<< 1;
            any_in    = 1'b0;
            if (l_da == 0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LINE;
            end
         end
         ST_LINE: begin
            pix_en_in = l_ok;
            pix_x_in  = px[XW-1:0];
            pix_y_in  = py[YW-1:0];
            any_in    = any_ff || l_ok;
            ln_a_in   = ln_a_ff + LW'(1);
            if (ln_d_ff > 0) begin
               ln_b_in = ln_dec_ff ? ln_b_ff - LW'(1) : ln_b_ff + LW'(1);
               ln_d_in = ln_d_ff + ln_k1_ff;
            end else begin
               ln_d_in = ln_d_ff + ln_k2_ff;
            end
            if (ln_a_ff + LW'(1) == ln_a1_ff) begin
               rej_in   = !(any_ff || l_ok);
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            sw_in = sw_ff + AW'(1);
            if (sw_ff == sw_end_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         draw_sel_ff <= 1'b0;
         pix_en_ff   <= 1'b0;
         sw_ff       <= '0;
         sw_end_ff   <= SW_ALL;
      end else begin
         state_ff    <= state_in;
         draw_sel_ff <= draw_sel_in;
         pix_en_ff   <= pix_en_in;
         sw_ff       <= sw_in;
         sw_end_ff   <= sw_end_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rej_ff       <= rej_in;
      rd_ff        <= rd_in;
      any_ff       <= any_in;
      outline_ff   <= outline_in;
      side_ff      <= side_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      ey1_ff       <= ey1_in;
      ex3_ff       <= ex3_in;
      color_ff     <= color_in;
      sc_x_ff      <= sc_x_in;
      sc_x0_ff     <= sc_x0_in;
      sc_xe_ff     <= sc_xe_in;
      sc_y_ff      <= sc_y_in;
      sc_ye_ff     <= sc_ye_in;
      major_ff     <= major_in;
      ln_a_ff      <= ln_a_in;
      ln_b_ff      <= ln_b_in;
      ln_a1_ff     <= ln_a1_in;
      ln_d_ff      <= ln_d_in;
      ln_k1_ff     <= ln_k1_in;
      ln_k2_ff     <= ln_k2_in;
      ln_dec_ff    <= ln_dec_in;
      pix_rd_ff    <= pix_rd_in;
      pix_plane_ff <= pix_plane_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
   end

   // frame store access: sweep or one pixel
   assign sweeping  = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);
   assign pix_addr  = (pix_plane_ff ? PLANE : '0) + AW'(pix_y_ff) * ROW + AW'(pix_x_ff);
   assign mem_we    = sweeping || (pix_en_ff && !pix_rd_ff);
   assign mem_re    = pix_en_ff && pix_rd_ff;
   assign mem_addr  = sweeping ? sw_ff : pix_addr;
   assign mem_wdata = sweeping ? '0 : color_ff;

   assign stat.done     = (state_ff == ST_DONE);
   assign stat.rejected = rej_ff;
   assign stat.rd       = rd_ff;

   a_rw_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("frame store read and write in the same cycle");

   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !pix_en_ff)
      else $error("pixel access during a sweep");

   a_line_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINE) |-> (ln_a_ff < ln_a1_ff))
      else $error("line walk past its end point");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command accepted without going busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !stat.done)
      else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/core/framebuffer_line_rect_rasterizer_unit.sv =====
// channel   ports                              transaction when
// command   start, busy, req_data              start high and busy low
// result    rsp_valid, rsp_data                rsp_valid high, one cycle
// config    csr_we, csr_index, csr_wdata       csr_we high
//
// the one write port of the frame store sets the pace of one pixel per cycle.
// clear zeroes the MAX_RES_X*MAX_RES_Y words of the drawing plane, one word
// per cycle. after reset a pass zeroes both buffers, 2*MAX_RES_X*MAX_RES_Y
// words, with busy high; config writes are taken meanwhile.
// the result strobe follows the last cycle of a command; no backpressure.
module framebuffer_line_rect_rasterizer_unit import frlr_pkg::*; #(
   parameter int MAX_RES_X = DEF_MAX_RES_X,
   parameter int MAX_RES_Y = DEF_MAX_RES_Y
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [RES_W-1:0] csr_wdata
);

   localparam int XE = $clog2(MAX_RES_X + 1);
   localparam int YE = $clog2(MAX_RES_Y + 1);
   localparam int DEPTH = 2 * MAX_RES_X * MAX_RES_Y;
   localparam int AW = $clog2(DEPTH);

   logic [RES_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [CMPW-1:0] rx_w, ry_w, rx_c, ry_c;
   logic [XE-1:0] act_w;
   logic [YE-1:0] act_h;
   logic mem_we, mem_re;
   logic [AW-1:0] mem_addr;
   logic [COLOR_W-1:0] mem_wdata, mem_rdata;
   stat_type stat;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   // configuration writes
   always_comb begin
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_RES_X: res_x_in = csr_wdata;
            CSR_RES_Y: res_y_in = csr_wdata;
            default: begin
               res_x_in = res_x_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_x_ff <= RES_RESET;
         res_y_ff <= RES_RESET;
      end else begin
         res_x_ff <= res_x_in;
         res_y_ff <= res_y_in;
      end
   end

   // effective screen size, clamped to 1 .. max
   always_comb begin
      rx_w = CMPW'(res_x_ff);
      ry_w = CMPW'(res_y_ff);
      if (rx_w == '0) begin
         rx_c = CMPW'(1);
      end else if (rx_w > CMPW'(MAX_RES_X)) begin
         rx_c = CMPW'(MAX_RES_X);
      end else begin
         rx_c = rx_w;
      end
      if (ry_w == '0) begin
         ry_c = CMPW'(1);
      end else if (ry_w > CMPW'(MAX_RES_Y)) begin
         ry_c = CMPW'(MAX_RES_Y);
      end else begin
         ry_c = ry_w;
      end
   end

   assign act_w = rx_c[XE-1:0];
   assign act_h = ry_c[YE-1:0];

   frlr_seq #(
      .MAX_RES_X(MAX_RES_X),
      .MAX_RES_Y(MAX_RES_Y)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .act_w     (act_w),
      .act_h     (act_h),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .stat      (stat)
   );

   frlr_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(DEPTH)
   ) u_frame (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_addr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_addr),
      .rdata (mem_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stat.done;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_data_ff.pixel_value <= stat.rd ? mem_rdata : '0;
         rsp_data_ff.rejected    <= stat.rejected;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
